### sv/assert_macros.svh
// assertion macros for the packer rtl, included by the top level file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication with the consequent checked in the next cycle
`define BCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bcp_pkg.sv
// types, constants and helpers of the byte to coefficient packer
`timescale 1ns / 1ps
`default_nettype none

package bcp_pkg;

  localparam int unsigned COEFF_W = 64;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned REM_W   = 4;

  localparam logic [REM_W-1:0] BYTE_BITS   = 4'd8;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 7'd1;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = 7'd64;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [COEFF_W-1:0] coefficient;
    logic               last_coeff;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       byte_bits;
    logic [REM_W-1:0] rem;
    logic             last;
  } hold_t;

  typedef struct packed {
    logic               emit;
    logic               done;
    out_item_t          item;
    logic [COEFF_W-1:0] partial_n;
    logic [CFG_W-1:0]   filled_n;
    logic [7:0]         byte_n;
    logic [REM_W-1:0]   rem_n;
  } step_res_t;

  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] w;
    w = raw;
    if (raw == '0) begin
      w = WIDTH_MIN;
    end else if (raw > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/bcp_step.sv
// one packing step: consumes bits of the held byte, produces at most one coefficient
`timescale 1ns / 1ps
`default_nettype none

module bcp_step (
  input  var bcp_pkg::hold_t                      hold_i,
  input  var logic [bcp_pkg::COEFF_W-1:0]         partial_i,
  input  var logic [bcp_pkg::CFG_W-1:0]           filled_i,
  input  var logic [bcp_pkg::CFG_W-1:0]           width_i,
  output bcp_pkg::step_res_t                      res_o
);

  logic [bcp_pkg::CFG_W-1:0]   gap;
  logic [bcp_pkg::REM_W-1:0]   k1;
  logic [bcp_pkg::REM_W-1:0]   r2;
  logic                        full;
  logic [bcp_pkg::COEFF_W-1:0] chunk;
  logic [bcp_pkg::COEFF_W-1:0] partial_a;
  logic [bcp_pkg::COEFF_W-1:0] mask;
  logic [bcp_pkg::CFG_W-1:0]   filled_a;
  logic [bcp_pkg::CFG_W-1:0]   pad;
  logic [7:0]                  shifted;
  logic [7:0]                  rest;

  always_comb begin
    gap  = width_i - filled_i;
    k1   = hold_i.rem;
    full = 1'b0;
    if (filled_i >= width_i) begin
      k1   = 4'd1;
      full = 1'b1;
    end else if (gap <= {3'b000, hold_i.rem}) begin
      k1   = gap[bcp_pkg::REM_W-1:0];
      full = 1'b1;
    end
    r2        = hold_i.rem - k1;
    chunk     = {56'd0, hold_i.byte_bits} >> (bcp_pkg::BYTE_BITS - k1);
    partial_a = (partial_i << k1) | chunk;
    mask      = {bcp_pkg::COEFF_W{1'b1}} >> (bcp_pkg::WIDTH_MAX - width_i);
    filled_a  = filled_i + {3'b000, hold_i.rem};
    pad       = width_i - filled_a;
    shifted   = hold_i.byte_bits << k1;
    rest      = shifted >> (bcp_pkg::BYTE_BITS - r2);

    res_o = '0;
    if (full) begin
      res_o.emit             = 1'b1;
      res_o.item.coefficient = partial_a & mask;
      res_o.item.last_coeff  = hold_i.last && (r2 == '0);
      if ({3'b000, r2} < width_i) begin
        // leftover bits of this byte start the next coefficient
        res_o.partial_n = {56'd0, rest};
        res_o.filled_n  = {3'b000, r2};
        res_o.rem_n     = '0;
      end else begin
        res_o.partial_n = '0;
        res_o.filled_n  = '0;
        res_o.rem_n     = r2;
        res_o.byte_n    = shifted;
      end
      res_o.done = (res_o.rem_n == '0) && !(hold_i.last && (res_o.filled_n != '0));
    end else begin
      res_o.done = 1'b1;
      if (hold_i.last && (filled_a != '0)) begin
        // flush: partial left aligned, low bits zero
        res_o.emit             = 1'b1;
        res_o.item.coefficient = (partial_a << pad[5:0]) & mask;
        res_o.item.last_coeff  = 1'b1;
        res_o.partial_n        = '0;
        res_o.filled_n         = '0;
      end else begin
        res_o.partial_n = partial_a;
        res_o.filled_n  = filled_a;
      end
    end
  end

endmodule

`default_nettype wire

### sv/bcp_out_reg.sv
// result register with valid and ready toward the consumer
`timescale 1ns / 1ps
`default_nettype none

module bcp_out_reg (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  input  var logic                  load_i,
  input  var bcp_pkg::out_item_t    item_i,
  output logic                      space_o,
  output logic                      out_valid_o,
  input  var logic                  out_ready_i,
  output bcp_pkg::out_item_t        out_data_o
);

  logic               valid_q;
  bcp_pkg::out_item_t item_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

### sv/byte_to_coefficient_packer.sv
// top level of the byte to coefficient packer
//
//  port group   dir  handshake                  payload
//  in_*         in   in_valid_i / in_ready_o     bcp_pkg::in_item_t
//  out_*        out  out_valid_o / out_ready_i   bcp_pkg::out_item_t
//  cfg_*        in   cfg_valid_i / cfg_ready_o   coeff_bits, 7 bits
//
//  a byte sits in one holding register; each cycle one step consumes its bits and
//  loads at most one coefficient into the result register, unless the step stalls
//  width 8 or more: one byte per cycle while the step does not stall; a final byte
//  that both completes a coefficient and leaves a partial one is held to flush it
//  width below 8: a byte may yield more than one coefficient, at most one per step,
//  bounded by the single result register; reset clears all control state and sets
//  the width to 16; a stalled consumer holds only a step that produces a coefficient
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module byte_to_coefficient_packer (
  input  var logic                        clk_i,
  input  var logic                        rst_ni,
  input  var logic                        in_valid_i,
  output logic                            in_ready_o,
  input  var bcp_pkg::in_item_t           in_data_i,
  output logic                            out_valid_o,
  input  var logic                        out_ready_i,
  output bcp_pkg::out_item_t              out_data_o,
  input  var logic                        cfg_valid_i,
  output logic                            cfg_ready_o,
  input  var logic [bcp_pkg::CFG_W-1:0]   cfg_data_i
);

  logic                        hold_valid_q;
  bcp_pkg::hold_t              hold_q;
  logic [bcp_pkg::COEFF_W-1:0] partial_q;
  logic [bcp_pkg::CFG_W-1:0]   filled_q;
  logic [bcp_pkg::CFG_W-1:0]   width_q;
  bcp_pkg::step_res_t          res;
  logic                        out_space;
  logic                        step_fire;

  assign cfg_ready_o = 1'b1;
  assign step_fire   = hold_valid_q && (!res.emit || out_space);
  assign in_ready_o  = !hold_valid_q || (step_fire && res.done);

  bcp_step u_step (
    .hold_i    (hold_q),
    .partial_i (partial_q),
    .filled_i  (filled_q),
    .width_i   (width_q),
    .res_o     (res)
  );

  bcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_fire && res.emit),
    .item_i      (res.item),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      partial_q    <= '0;
      filled_q     <= '0;
      width_q      <= bcp_pkg::WIDTH_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= bcp_pkg::eff_width(cfg_data_i);
      end
      if (step_fire) begin
        partial_q <= res.partial_n;
        filled_q  <= res.filled_n;
      end
      if (in_valid_i && in_ready_o) begin
        hold_valid_q <= 1'b1;
      end else if (step_fire && res.done) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hold_q.byte_bits <= in_data_i.data_byte;
      hold_q.rem       <= bcp_pkg::BYTE_BITS;
      hold_q.last      <= in_data_i.last_byte;
    end else if (step_fire) begin
      hold_q.byte_bits <= res.byte_n;
      hold_q.rem       <= res.rem_n;
    end
  end

  // a drained byte is only held to flush the partial coefficient
  `BCP_ASSERT(a_flush_pending, clk_i, rst_ni,
    !(hold_valid_q && hold_q.rem == '0) || (hold_q.last && filled_q != '0),
    "held byte with no bits left but nothing to flush")
  `BCP_ASSERT(a_rem_range, clk_i, rst_ni,
    !hold_valid_q || hold_q.rem <= bcp_pkg::BYTE_BITS,
    "held bit count above byte size")
  `BCP_ASSERT(a_width_range, clk_i, rst_ni,
    width_q >= bcp_pkg::WIDTH_MIN && width_q <= bcp_pkg::WIDTH_MAX,
    "effective width out of range")
  `BCP_ASSERT(a_filled_range, clk_i, rst_ni,
    filled_q < bcp_pkg::WIDTH_MAX,
    "partial coefficient holds a full word")
  `BCP_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni,
    step_fire && res.emit, out_valid_o,
    "produced coefficient missing from result register")

endmodule

`default_nettype wire
